[design/bma_pkg.sv]
// Shared types, constants and codes for the binned moment accumulator.
`default_nettype none
package bma_pkg;

  localparam int NUM_E_BINS_DEF = 32;
  localparam int NUM_R_BINS_DEF = 32;

  localparam int BIN_AW = 16;
  localparam int RIDX_W = 8;

  localparam logic [15:0] LOWEST_RESET  = 16'd25600;
  localparam logic [15:0] E_LOW_RESET   = 16'd0;
  localparam logic [15:0] E_HIGH_RESET  = 16'd7680;
  localparam logic [15:0] R_LOW_RESET   = 16'd0;
  localparam logic [15:0] R_HIGH_RESET  = 16'd13107;
  localparam logic [15:0] E_STEP_RESET  = 16'd233;
  localparam logic [15:0] R_STEP_RESET  = 16'd397;

  localparam logic [2:0] CFG_E_LOW  = 3'd0;
  localparam logic [2:0] CFG_E_HIGH = 3'd1;
  localparam logic [2:0] CFG_R_LOW  = 3'd2;
  localparam logic [2:0] CFG_R_HIGH = 3'd3;
  localparam logic [2:0] CFG_E_STEP = 3'd4;
  localparam logic [2:0] CFG_R_STEP = 3'd5;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {OP_ADD, OP_READ, OP_CLEAR} op_t;
  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_EXEC} back_state_t;

  typedef struct packed {
    logic [15:0] e_low;
    logic [15:0] e_high;
    logic [15:0] r_low;
    logic [15:0] r_high;
    logic [15:0] e_step;
    logic [15:0] r_step;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic               binned;
    logic               low_ok;
    logic [BIN_AW-1:0]  bin;
    logic [RIDX_W-1:0]  nr;
    logic [15:0]        energy;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [31:0]        sqx;
    logic [31:0]        sqy;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        cnt;
    logic signed [47:0] sx;
    logic signed [47:0] sy;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
  } stat_t;

endpackage
`default_nettype wire

[design/binned_moment_accumulator.sv]
// Binned moment accumulator top level: configuration registers, front, queue and back.
// Usage:
//   Input words on in_* (valid/ready): func 0 adds a particle, 1 (or 3) reads a
//   bin, 2 clears a bin. Every input word yields exactly one result word on out_*.
//   Configuration writes on cfg_we/cfg_index/cfg_wdata take effect at once;
//   the user makes them only while the block is idle, which the block leaves unchecked.
//   An add goes through the bin-index divider (one quotient bit per cycle,
//   energy and radius divided in parallel) before it is queued. Reads and clears
//   skip the divider. The front takes no new word until the last one is queued;
//   the back end handles each word in its idle, read and execute states for the
//   bin memory read-modify-write.
//   After reset the back end sweeps all NUM_E_BINS*NUM_R_BINS bin entries
//   (1024 by default), zeroing sums and setting lowest energies to 100.0;
//   in_ready stays low until the sweep is done.
//   When out_ready is low the result is held in the output register; the back end
//   stops after one more command and the two-entry queue and front fill before
//   in_ready drops.
`default_nettype none
module binned_moment_accumulator #(
  parameter int NUM_E_BINS = bma_pkg::NUM_E_BINS_DEF,
  parameter int NUM_R_BINS = bma_pkg::NUM_R_BINS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_func,
  input  wire logic [15:0]        in_energy,
  input  wire logic [15:0]        in_radius,
  input  wire logic signed [15:0] in_slope_x,
  input  wire logic signed [15:0] in_slope_y,
  input  wire logic [4:0]         in_energy_index,
  input  wire logic [4:0]         in_radius_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_accepted,
  output logic [31:0]             out_bin_count,
  output logic signed [47:0]      out_sum_slope_x,
  output logic signed [47:0]      out_sum_slope_y,
  output logic [63:0]             out_sum_sq_slope_x,
  output logic [63:0]             out_sum_sq_slope_y,
  output logic [15:0]             out_lowest_energy_out,
  output logic [31:0]             out_total_points
);

  bma_pkg::cfg_t cfg_r;
  bma_pkg::cmd_t cmd, head;
  logic          clearing, push, full, pop, nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.e_low  <= bma_pkg::E_LOW_RESET;
      cfg_r.e_high <= bma_pkg::E_HIGH_RESET;
      cfg_r.r_low  <= bma_pkg::R_LOW_RESET;
      cfg_r.r_high <= bma_pkg::R_HIGH_RESET;
      cfg_r.e_step <= bma_pkg::E_STEP_RESET;
      cfg_r.r_step <= bma_pkg::R_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bma_pkg::CFG_E_LOW:  cfg_r.e_low  <= cfg_wdata;
        bma_pkg::CFG_E_HIGH: cfg_r.e_high <= cfg_wdata;
        bma_pkg::CFG_R_LOW:  cfg_r.r_low  <= cfg_wdata;
        bma_pkg::CFG_R_HIGH: cfg_r.r_high <= cfg_wdata;
        bma_pkg::CFG_E_STEP: cfg_r.e_step <= cfg_wdata;
        bma_pkg::CFG_R_STEP: cfg_r.r_step <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bma_front #(.NUM_E_BINS(NUM_E_BINS), .NUM_R_BINS(NUM_R_BINS)) u_front (
    .clk, .rst_n, .cfg(cfg_r), .clearing, .in_valid, .in_ready, .in_func, .in_energy,
    .in_radius, .in_slope_x, .in_slope_y, .in_energy_index, .in_radius_index,
    .push, .full, .cmd
  );

  bma_fifo u_fifo (
    .clk, .rst_n, .push, .wdata(cmd), .full, .pop, .nonempty, .head
  );

  bma_back #(.NUM_E_BINS(NUM_E_BINS), .NUM_R_BINS(NUM_R_BINS)) u_back (
    .clk, .rst_n, .clearing, .nonempty, .head, .pop, .out_valid, .out_ready,
    .out_accepted, .out_bin_count, .out_sum_slope_x, .out_sum_slope_y,
    .out_sum_sq_slope_x, .out_sum_sq_slope_y, .out_lowest_energy_out, .out_total_points
  );

endmodule
`default_nettype wire

[design/bma_div.sv]
// Restoring divider, one quotient bit per cycle, 17-bit dividend by 16-bit divisor.
`default_nettype none
module bma_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [16:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [16:0]      quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] dvd_r, dvd_nxt;
  logic [15:0] div_r, div_nxt;
  logic [16:0] sh;
  logic        qbit;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    sh       = {rem_r, dvd_r[16]};
    qbit     = (sh >= {1'b0, div_r});
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = 16'd0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? 16'(sh - {1'b0, div_r}) : sh[15:0];
      dvd_nxt = {dvd_r[15:0], qbit};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd16) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
`default_nettype wire

[design/bma_front.sv]
// Front end: accepts input words, finds bin indices and window flags, queues commands.
`default_nettype none
module bma_front #(
  parameter int NUM_E_BINS = bma_pkg::NUM_E_BINS_DEF,
  parameter int NUM_R_BINS = bma_pkg::NUM_R_BINS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bma_pkg::cfg_t      cfg,
  input  wire logic               clearing,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_func,
  input  wire logic [15:0]        in_energy,
  input  wire logic [15:0]        in_radius,
  input  wire logic signed [15:0] in_slope_x,
  input  wire logic signed [15:0] in_slope_y,
  input  wire logic [4:0]         in_energy_index,
  input  wire logic [4:0]         in_radius_index,
  output logic                    push,
  input  wire logic               full,
  output bma_pkg::cmd_t           cmd
);

  bma_pkg::front_state_t state_r, state_nxt;

  bma_pkg::op_t       op_r;
  logic [15:0]        e_r, r_r;
  logic signed [15:0] sx_r, sy_r;
  logic [4:0]         ei_r, ri_r;
  logic [31:0]        sqx_r, sqy_r;
  logic signed [31:0] px, py;

  logic        accept, start;
  logic [15:0] estep, rstep;
  logic [16:0] e_dvd, r_dvd, qe, qr;
  logic        done_e, done_rad;
  logic [7:0]  ne, nr;
  logic [24:0] r_limit;

  assign accept = in_valid && in_ready;
  assign start  = accept && (in_func == bma_pkg::FUNC_ADD);
  assign estep  = (cfg.e_step == 16'd0) ? 16'd1 : cfg.e_step;
  assign rstep  = (cfg.r_step == 16'd0) ? 16'd1 : cfg.r_step;
  assign e_dvd  = 17'(in_energy) + 17'(estep) - 17'd1;
  assign r_dvd  = 17'(in_radius) + 17'(rstep) - 17'd1;

  bma_div u_div_e (
    .clk, .rst_n, .start, .dividend(e_dvd), .divisor(estep), .done(done_e), .quotient(qe)
  );
  bma_div u_div_r (
    .clk, .rst_n, .start, .dividend(r_dvd), .divisor(rstep), .done(done_rad),
    .quotient(qr)
  );

  assign px = sx_r * sx_r;
  assign py = sy_r * sy_r;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      bma_pkg::F_IDLE: begin
        in_ready = !clearing;
        if (in_valid && !clearing) begin
          state_nxt = (in_func == bma_pkg::FUNC_ADD) ? bma_pkg::F_DIV : bma_pkg::F_PUSH;
        end
      end
      bma_pkg::F_DIV: begin
        if (done_e && done_rad) state_nxt = bma_pkg::F_PUSH;
      end
      bma_pkg::F_PUSH: begin
        if (!full) begin
          push      = 1'b1;
          state_nxt = bma_pkg::F_IDLE;
        end
      end
      default: state_nxt = bma_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    if (op_r == bma_pkg::OP_ADD) begin
      if (qe == 17'd0 || (qe - 17'd1) >= 17'(NUM_E_BINS)) ne = 8'(NUM_E_BINS - 1);
      else ne = 8'(qe - 17'd1);
      if (qr == 17'd0 || (qr - 17'd1) >= 17'(NUM_R_BINS)) nr = 8'(NUM_R_BINS - 1);
      else nr = 8'(qr - 17'd1);
    end else begin
      ne = (9'(ei_r) >= 9'(NUM_E_BINS)) ? 8'(NUM_E_BINS - 1) : 8'(ei_r);
      nr = (9'(ri_r) >= 9'(NUM_R_BINS)) ? 8'(NUM_R_BINS - 1) : 8'(ri_r);
    end
    r_limit    = 25'(NUM_R_BINS) * 25'(rstep);
    cmd.op     = op_r;
    cmd.low_ok = (r_r != 16'd0) && (25'(r_r) < r_limit);
    cmd.binned = (e_r > cfg.e_low) && (e_r < cfg.e_high) &&
                 (r_r > cfg.r_low) && (r_r < cfg.r_high);
    cmd.bin    = 16'(16'(ne) * 16'(NUM_R_BINS) + 16'(nr));
    cmd.nr     = nr;
    cmd.energy = e_r;
    cmd.sx     = sx_r;
    cmd.sy     = sy_r;
    cmd.sqx    = sqx_r;
    cmd.sqy    = sqy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bma_pkg::F_IDLE;
    else state_r <= state_nxt;
    if (accept) begin
      unique case (in_func)
        bma_pkg::FUNC_ADD:   op_r <= bma_pkg::OP_ADD;
        bma_pkg::FUNC_CLEAR: op_r <= bma_pkg::OP_CLEAR;
        default:             op_r <= bma_pkg::OP_READ;
      endcase
      e_r  <= in_energy;
      r_r  <= in_radius;
      sx_r <= in_slope_x;
      sy_r <= in_slope_y;
      ei_r <= in_energy_index;
      ri_r <= in_radius_index;
    end
    sqx_r <= 32'(unsigned'(px));
    sqy_r <= 32'(unsigned'(py));
  end

endmodule
`default_nettype wire

[design/bma_fifo.sv]
// Two-entry command queue between front and back.
`default_nettype none
module bma_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bma_pkg::cmd_t wdata,
  output logic               full,
  input  wire logic          pop,
  output logic               nonempty,
  output bma_pkg::cmd_t      head
);

  bma_pkg::cmd_t slot_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign head     = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) slot_r[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

[design/bma_back.sv]
// Back end: bin memories, read-modify-write of moment sums, output register.
`default_nettype none
module bma_back #(
  parameter int NUM_E_BINS = bma_pkg::NUM_E_BINS_DEF,
  parameter int NUM_R_BINS = bma_pkg::NUM_R_BINS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  output logic               clearing,
  input  wire logic          nonempty,
  input  wire bma_pkg::cmd_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_accepted,
  output logic [31:0]        out_bin_count,
  output logic signed [47:0] out_sum_slope_x,
  output logic signed [47:0] out_sum_slope_y,
  output logic [63:0]        out_sum_sq_slope_x,
  output logic [63:0]        out_sum_sq_slope_y,
  output logic [15:0]        out_lowest_energy_out,
  output logic [31:0]        out_total_points
);

  localparam int NBINS = NUM_E_BINS * NUM_R_BINS;
  localparam int AW    = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int RW    = (NUM_R_BINS > 1) ? $clog2(NUM_R_BINS) : 1;

  bma_pkg::back_state_t state_r, state_nxt;

  bma_pkg::stat_t stat_mem [NBINS];
  logic [15:0]    low_mem [NUM_R_BINS];
  bma_pkg::stat_t rd_stat;
  logic [15:0]    rd_low;

  bma_pkg::cmd_t  cmd_r;
  logic [AW-1:0]  clr_r, clr_nxt;
  logic [31:0]    total_r, total_nxt;

  logic           st_we, low_we;
  logic [AW-1:0]  st_wa;
  logic [RW-1:0]  low_wa;
  bma_pkg::stat_t st_wd, upd;
  logic [15:0]    low_wd;

  logic           ov_r, ov_nxt, load;
  logic           acc_nxt;
  bma_pkg::stat_t ostat_nxt;
  logic [15:0]    olow_nxt;

  logic signed [48:0] ax, ay;
  logic [64:0]        aqx, aqy;

  always_comb begin
    ax      = 49'(rd_stat.sx) + 49'(cmd_r.sx);
    ay      = 49'(rd_stat.sy) + 49'(cmd_r.sy);
    aqx     = {1'b0, rd_stat.sqx} + 65'(cmd_r.sqx);
    aqy     = {1'b0, rd_stat.sqy} + 65'(cmd_r.sqy);
    upd.cnt = (rd_stat.cnt == '1) ? rd_stat.cnt : rd_stat.cnt + 32'd1;
    if (ax[48] != ax[47]) upd.sx = ax[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else upd.sx = ax[47:0];
    if (ay[48] != ay[47]) upd.sy = ay[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else upd.sy = ay[47:0];
    upd.sqx = aqx[64] ? '1 : aqx[63:0];
    upd.sqy = aqy[64] ? '1 : aqy[63:0];
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    total_nxt = total_r;
    pop       = 1'b0;
    clearing  = 1'b0;
    load      = 1'b0;
    st_we     = 1'b0;
    low_we    = 1'b0;
    st_wa     = cmd_r.bin[AW-1:0];
    low_wa    = cmd_r.nr[RW-1:0];
    st_wd     = '0;
    low_wd    = rd_low;
    acc_nxt   = 1'b0;
    ostat_nxt = '0;
    olow_nxt  = rd_low;
    ov_nxt    = ov_r && !out_ready;
    unique case (state_r)
      bma_pkg::B_CLEAR: begin
        clearing = 1'b1;
        st_we    = 1'b1;
        st_wa    = clr_r;
        low_we   = (32'(clr_r) < 32'(NUM_R_BINS));
        low_wa   = RW'(clr_r);
        low_wd   = bma_pkg::LOWEST_RESET;
        clr_nxt  = clr_r + AW'(1);
        if (32'(clr_r) == 32'(NBINS - 1)) state_nxt = bma_pkg::B_IDLE;
      end
      bma_pkg::B_IDLE: begin
        if (nonempty) begin
          pop       = 1'b1;
          state_nxt = bma_pkg::B_READ;
        end
      end
      bma_pkg::B_READ: state_nxt = bma_pkg::B_EXEC;
      bma_pkg::B_EXEC: begin
        if (!ov_r || out_ready) begin
          load      = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = bma_pkg::B_IDLE;
          unique case (cmd_r.op)
            bma_pkg::OP_ADD: begin
              if (cmd_r.low_ok && cmd_r.energy < rd_low) begin
                low_we   = 1'b1;
                low_wd   = cmd_r.energy;
                olow_nxt = cmd_r.energy;
              end
              if (cmd_r.binned) begin
                st_we     = 1'b1;
                st_wd     = upd;
                ostat_nxt = upd;
                acc_nxt   = 1'b1;
                if (total_r != '1) total_nxt = total_r + 32'd1;
              end
            end
            bma_pkg::OP_CLEAR: st_we = 1'b1;
            default: ostat_nxt = rd_stat;
          endcase
        end
      end
      default: state_nxt = bma_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) stat_mem[st_wa] <= st_wd;
    if (low_we) low_mem[low_wa] <= low_wd;
    rd_stat <= stat_mem[cmd_r.bin[AW-1:0]];
    rd_low  <= low_mem[cmd_r.nr[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bma_pkg::B_CLEAR;
      clr_r   <= '0;
      total_r <= 32'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
    if (pop) cmd_r <= head;
    if (load) begin
      out_accepted          <= acc_nxt;
      out_bin_count         <= ostat_nxt.cnt;
      out_sum_slope_x       <= ostat_nxt.sx;
      out_sum_slope_y       <= ostat_nxt.sy;
      out_sum_sq_slope_x    <= ostat_nxt.sqx;
      out_sum_sq_slope_y    <= ostat_nxt.sqy;
      out_lowest_energy_out <= olow_nxt;
      out_total_points      <= total_nxt;
    end
  end

  assign out_valid = ov_r;

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the binned moment accumulator: directed and random adds, reads, clears.
`default_nettype none
module tb_top;

  localparam int NE = 32;
  localparam int NR = 32;
  localparam longint S48MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint S48MIN = -S48MAX - 1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] energy;
    logic [15:0] radius;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [4:0]  ei;
    logic [4:0]  ri;
  } word_t;

  typedef struct {
    logic        accepted;
    logic [31:0] cnt;
    logic [47:0] sx;
    logic [47:0] sy;
    logic [63:0] sqx;
    logic [63:0] sqy;
    logic [15:0] lowest;
    logic [31:0] total;
  } res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic [15:0] in_energy = '0, in_radius = '0;
  logic signed [15:0] in_slope_x = '0, in_slope_y = '0;
  logic [4:0] in_energy_index = '0, in_radius_index = '0;
  logic out_valid;
  logic out_ready = 0;
  logic out_accepted;
  logic [31:0] out_bin_count, out_total_points;
  logic signed [47:0] out_sum_slope_x, out_sum_slope_y;
  logic [63:0] out_sum_sq_slope_x, out_sum_sq_slope_y;
  logic [15:0] out_lowest_energy_out;

  binned_moment_accumulator u_dut (.*);

  initial forever #4 clk = ~clk;

  // histogram mirror
  logic [15:0] e_lo, e_hi, r_lo, r_hi, e_stp, r_stp;
  logic [31:0] h_cnt [NE*NR];
  longint      h_sx [NE*NR];
  longint      h_sy [NE*NR];
  logic [63:0] h_sqx [NE*NR];
  logic [63:0] h_sqy [NE*NR];
  logic [15:0] h_low [NR];
  logic [31:0] h_total;

  word_t pending[$];
  res_t  expected_res[$];
  int errors = 0;
  int cycles = 0;

  function automatic int bin_index(logic [15:0] v, logic [15:0] stp, int nb);
    int s, k;
    s = (stp == 0) ? 1 : stp;
    k = (int'(v) + s - 1) / s;
    if (k == 0) return nb - 1;
    return (k - 1 >= nb) ? nb - 1 : k - 1;
  endfunction

  function automatic longint add48(longint a, longint b);
    longint r;
    r = a + b;
    if (r > S48MAX) return S48MAX;
    if (r < S48MIN) return S48MIN;
    return r;
  endfunction

  function automatic logic [63:0] addu64(logic [63:0] a, logic [63:0] b);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[64] ? '1 : r[63:0];
  endfunction

  function automatic res_t histogram_apply(word_t w);
    res_t r;
    int b, nr, ne, ei, ri, rs;
    longint sx, sy;
    bit show;
    sx = longint'($signed(w.sx));
    sy = longint'($signed(w.sy));
    r.accepted = 0;
    show = 1;
    b = 0;
    if (w.func == bma_pkg::FUNC_ADD) begin
      rs = (r_stp == 0) ? 1 : r_stp;
      nr = bin_index(w.radius, r_stp, NR);
      if (w.radius > 0 && int'(w.radius) < NR * rs && w.energy < h_low[nr])
        h_low[nr] = w.energy;
      if (w.energy > e_lo && w.energy < e_hi && w.radius > r_lo && w.radius < r_hi) begin
        ne = bin_index(w.energy, e_stp, NE);
        b = ne * NR + nr;
        if (h_cnt[b] != '1) h_cnt[b]++;
        if (h_total != '1) h_total++;
        h_sx[b] = add48(h_sx[b], sx);
        h_sy[b] = add48(h_sy[b], sy);
        h_sqx[b] = addu64(h_sqx[b], 64'(sx * sx));
        h_sqy[b] = addu64(h_sqy[b], 64'(sy * sy));
        r.accepted = 1;
      end else show = 0;
    end else begin
      ei = (w.ei >= NE) ? NE - 1 : w.ei;
      ri = (w.ri >= NR) ? NR - 1 : w.ri;
      nr = ri;
      b = ei * NR + ri;
      if (w.func == bma_pkg::FUNC_CLEAR) begin
        h_cnt[b] = 0; h_sx[b] = 0; h_sy[b] = 0; h_sqx[b] = 0; h_sqy[b] = 0;
      end
    end
    r.cnt = show ? h_cnt[b] : '0;
    r.sx = show ? h_sx[b][47:0] : '0;
    r.sy = show ? h_sy[b][47:0] : '0;
    r.sqx = show ? h_sqx[b] : '0;
    r.sqy = show ? h_sqy[b] : '0;
    r.lowest = h_low[nr];
    r.total = h_total;
    return r;
  endfunction

  function automatic void enqueue(word_t w);
    pending = {pending, w};
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      bma_pkg::CFG_E_LOW:  e_lo = v;
      bma_pkg::CFG_E_HIGH: e_hi = v;
      bma_pkg::CFG_R_LOW:  r_lo = v;
      bma_pkg::CFG_R_HIGH: r_hi = v;
      bma_pkg::CFG_E_STEP: e_stp = v;
      bma_pkg::CFG_R_STEP: r_stp = v;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || expected_res.size() != 0 || in_valid) @(posedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic word_t mk(logic [1:0] f, logic [15:0] e, logic [15:0] r,
                               logic [15:0] x, logic [15:0] y,
                               logic [4:0] ei, logic [4:0] ri);
    word_t w;
    w.func = f; w.energy = e; w.radius = r; w.sx = x; w.sy = y; w.ei = ei; w.ri = ri;
    return w;
  endfunction

  function automatic word_t rand_word(bit inwin);
    word_t w;
    int p;
    w = mk(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           5'($urandom), 5'($urandom));
    p = $urandom_range(0, 99);
    w.func = (p < 70) ? bma_pkg::FUNC_ADD : (p < 85) ? bma_pkg::FUNC_READ :
             (p < 95) ? bma_pkg::FUNC_CLEAR : FUNC_SPARE;
    if (inwin && e_hi > e_lo + 1 && r_hi > r_lo + 1) begin
      w.energy = 16'($urandom_range(e_lo + 1, e_hi - 1));
      w.radius = 16'($urandom_range(r_lo + 1, r_hi - 1));
    end
    if ($urandom_range(0, 7) == 0) w.sx = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    return w;
  endfunction

  // driver
  int in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && in_ready) begin
      in_valid <= 0;
      expected_res = {expected_res,
                      histogram_apply(mk(in_func, in_energy, in_radius, in_slope_x,
                                         in_slope_y, in_energy_index, in_radius_index))};
    end
  end

  always @(negedge clk) begin
    if (rst_n && !in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending.size() != 0) begin
        word_t w;
        w = pending.pop_front();
        in_valid <= 1;
        in_func <= w.func; in_energy <= w.energy; in_radius <= w.radius;
        in_slope_x <= w.sx; in_slope_y <= w.sy;
        in_energy_index <= w.ei; in_radius_index <= w.ri;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
    end
  end

  // monitor
  int out_wait = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (out_valid && out_ready)
          out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, total %0d", $time, out_total_points);
      end else begin
        res_t x;
        x = expected_res.pop_front();
        if (out_accepted !== x.accepted || out_bin_count !== x.cnt ||
            out_sum_slope_x !== x.sx || out_sum_slope_y !== x.sy ||
            out_sum_sq_slope_x !== x.sqx || out_sum_sq_slope_y !== x.sqy ||
            out_lowest_energy_out !== x.lowest || out_total_points !== x.total) begin
          errors++;
          $display("%0t: mismatch exp acc=%0d cnt=%0d sx=%0h sy=%0h sqx=%0h sqy=%0h",
                   $time, x.accepted, x.cnt, x.sx, x.sy, x.sqx, x.sqy);
          $display("%0t:          exp low=%0d tot=%0d", $time, x.lowest, x.total);
          $display("%0t:          got acc=%0d cnt=%0d sx=%0h sy=%0h sqx=%0h sqy=%0h",
                   $time, out_accepted, out_bin_count, out_sum_slope_x, out_sum_slope_y,
                   out_sum_sq_slope_x, out_sum_sq_slope_y);
          $display("%0t:          got low=%0d tot=%0d", $time, out_lowest_energy_out,
                   out_total_points);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    e_lo = bma_pkg::E_LOW_RESET; e_hi = bma_pkg::E_HIGH_RESET;
    r_lo = bma_pkg::R_LOW_RESET; r_hi = bma_pkg::R_HIGH_RESET;
    e_stp = bma_pkg::E_STEP_RESET; r_stp = bma_pkg::R_STEP_RESET;
    for (int i = 0; i < NE*NR; i++) begin
      h_cnt[i] = 0; h_sx[i] = 0; h_sy[i] = 0; h_sqx[i] = 0; h_sqy[i] = 0;
    end
    for (int i = 0; i < NR; i++) h_low[i] = bma_pkg::LOWEST_RESET;
    h_total = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;

    // directed: reset settings
    enqueue(mk(bma_pkg::FUNC_ADD, 16'd1000, 16'd1000, 16'h7FFF, 16'h8000, 0, 0));
    enqueue(mk(bma_pkg::FUNC_ADD, 16'd1000, 16'd1000, 16'h8000, 16'h7FFF, 0, 0));
    enqueue(mk(bma_pkg::FUNC_ADD, 16'd0, 16'd0, 16'h0001, 16'hFFFF, 0, 0));
    enqueue(mk(bma_pkg::FUNC_ADD, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 0, 0));
    enqueue(mk(bma_pkg::FUNC_ADD, 16'd7679, 16'd13106, 16'h1234, 16'h4321, 0, 0));
    enqueue(mk(bma_pkg::FUNC_ADD, 16'd7680, 16'd100, 16'h1, 16'h1, 0, 0));
    enqueue(mk(bma_pkg::FUNC_ADD, 16'd233, 16'd397, 16'h5, 16'h5, 0, 0));
    enqueue(mk(bma_pkg::FUNC_ADD, 16'd234, 16'd398, 16'h5, 16'h5, 0, 0));
    enqueue(mk(bma_pkg::FUNC_READ, 0, 0, 0, 0, 5'd4, 5'd2));
    enqueue(mk(bma_pkg::FUNC_READ, 0, 0, 0, 0, 5'd31, 5'd31));
    enqueue(mk(FUNC_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd0, 5'd1));
    enqueue(mk(bma_pkg::FUNC_CLEAR, 0, 0, 0, 0, 5'd4, 5'd2));
    enqueue(mk(bma_pkg::FUNC_READ, 0, 0, 0, 0, 5'd4, 5'd2));
    wait_idle();

    // zero steps, full window
    write_reg(bma_pkg::CFG_E_STEP, 16'd0);
    write_reg(bma_pkg::CFG_R_STEP, 16'd0);
    write_reg(bma_pkg::CFG_E_HIGH, 16'hFFFF);
    write_reg(bma_pkg::CFG_R_HIGH, 16'hFFFF);
    enqueue(mk(bma_pkg::FUNC_ADD, 16'd1, 16'd1, 16'h8000, 16'h8000, 0, 0));
    enqueue(mk(bma_pkg::FUNC_ADD, 16'd31, 16'd31, 16'h7FFF, 16'h7FFF, 0, 0));
    enqueue(mk(bma_pkg::FUNC_ADD, 16'd32, 16'd33, 16'h7FFF, 16'h7FFF, 0, 0));
    enqueue(mk(bma_pkg::FUNC_ADD, 16'hFFFE, 16'hFFFE, 16'h0, 16'h0, 0, 0));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(bma_pkg::CFG_E_LOW, 16'd0);
          write_reg(bma_pkg::CFG_E_HIGH, bma_pkg::E_HIGH_RESET);
          write_reg(bma_pkg::CFG_R_LOW, 16'd0);
          write_reg(bma_pkg::CFG_R_HIGH, bma_pkg::R_HIGH_RESET);
          write_reg(bma_pkg::CFG_E_STEP, bma_pkg::E_STEP_RESET);
          write_reg(bma_pkg::CFG_R_STEP, bma_pkg::R_STEP_RESET);
        end
        1: begin
          write_reg(bma_pkg::CFG_E_STEP, 16'hFFFF); write_reg(bma_pkg::CFG_R_STEP, 16'hFFFF);
          write_reg(bma_pkg::CFG_E_HIGH, 16'hFFFF); write_reg(bma_pkg::CFG_R_HIGH, 16'hFFFF);
        end
        2: begin
          write_reg(bma_pkg::CFG_E_STEP, 16'd1); write_reg(bma_pkg::CFG_R_STEP, 16'd1);
          write_reg(bma_pkg::CFG_E_LOW, 16'd2); write_reg(bma_pkg::CFG_E_HIGH, 16'd40);
          write_reg(bma_pkg::CFG_R_LOW, 16'd3); write_reg(bma_pkg::CFG_R_HIGH, 16'd40);
        end
        3: begin
          write_reg(bma_pkg::CFG_E_STEP, 16'($urandom_range(1, 4000)));
          write_reg(bma_pkg::CFG_R_STEP, 16'($urandom_range(1, 4000)));
          write_reg(bma_pkg::CFG_E_LOW, 16'($urandom_range(0, 20000)));
          write_reg(bma_pkg::CFG_E_HIGH, 16'($urandom_range(30000, 65535)));
          write_reg(bma_pkg::CFG_R_LOW, 16'($urandom_range(0, 20000)));
          write_reg(bma_pkg::CFG_R_HIGH, 16'($urandom_range(30000, 65535)));
        end
        4: begin
          write_reg(bma_pkg::CFG_E_LOW, 16'hFFFF); write_reg(bma_pkg::CFG_R_LOW, 16'hFFFF);
        end
        default: begin
          write_reg(bma_pkg::CFG_E_LOW, 16'd0); write_reg(bma_pkg::CFG_R_LOW, 16'd0);
          write_reg(bma_pkg::CFG_E_HIGH, 16'hFFFF); write_reg(bma_pkg::CFG_R_HIGH, 16'hFFFF);
          write_reg(bma_pkg::CFG_E_STEP, 16'd2048); write_reg(bma_pkg::CFG_R_STEP, 16'd2048);
        end
      endcase
      for (int i = 0; i < 290; i++) enqueue(rand_word($urandom_range(0, 3) != 0));
      wait_idle();
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
